[design/srfc_pkg.sv]
// ----------------------------------------------------------------------------
// srfc_pkg
// Shared types and constants of the sensor reply frame classifier.
// ----------------------------------------------------------------------------
package srfc_pkg;

	localparam logic [7:0]  CHECK_SUM     = 8'haa;
	localparam logic [3:0]  MAJOR_OTHER   = 4'ha;
	localparam logic [3:0]  MAJOR_MSG     = 4'hb;
	localparam logic [2:0]  MINOR_EVK     = 3'd4;
	localparam logic [2:0]  MINOR_MSG_ACK = 3'd0;
	localparam logic [15:0] RESP_MAX      = 16'd64;
	localparam logic [15:0] ACK_MIN_PLEN  = 16'd2;
	localparam logic [16:0] COUNT_MAX     = 17'h1ffff;
	localparam logic [16:0] MIN_BODY      = 17'd4;
	localparam logic [16:0] LEN_OVERHEAD  = 17'd3;

	// Body byte positions of the header fields.
	localparam logic [16:0] POS_CMD     = 17'd0;
	localparam logic [16:0] POS_LEN_LO  = 17'd1;
	localparam logic [16:0] POS_LEN_HI  = 17'd2;
	localparam logic [16:0] POS_FIRST   = 17'd3;
	localparam logic [16:0] POS_SECOND  = 17'd4;

	localparam int TDATA_W = 48;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_SHORT   = 3'd1,
		ST_CMDBIT  = 3'd2,
		ST_LENGTH  = 3'd3,
		ST_SUM     = 3'd4,
		ST_ACKBIT  = 3'd5,
		ST_TOOLONG = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_ACK   = 2'd1,
		KIND_RESP  = 2'd2
	} kind_t;

	// Accumulated view of the body received so far.
	typedef struct packed {
		logic [16:0] count;
		logic [7:0]  sum;
		logic [7:0]  cmd;
		logic [15:0] len;
		logic [7:0]  first;
		logic [7:0]  second;
	} frame_snap_t;

	// Verdict fields; status sits in the lowest bits.
	typedef struct packed {
		logic [7:0]  ack_code;
		logic [2:0]  ack_minor;
		logic [3:0]  ack_major;
		logic [15:0] payload_length;
		logic [2:0]  cmd_minor;
		logic [3:0]  cmd_major;
		kind_t       kind;
		status_t     status;
	} result_t;

endpackage

[design/sensor_reply_frame_classifier.sv]
// ----------------------------------------------------------------------------
// sensor_reply_frame_classifier
// Classifies one framed sensor reply body per run of bytes ending in tlast.
// ----------------------------------------------------------------------------
// The verdict reaches m_tdata through the input register and then the result
// register: the last byte lands in the input register, and the result register
// loads the verdict once no earlier verdict is waiting there.
// The input takes one byte per cycle, with no gap between bodies, unless stalled.
// The only stall is a verdict still waiting in the result register.
// Reset clears the frame state and both valid flags at once.
module sensor_reply_frame_classifier (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte[7:0]
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [srfc_pkg::TDATA_W-1:0] m_tdata // status[2:0], kind[4:3],
	// cmd_major[8:5], cmd_minor[11:9], payload_length[27:12], ack_major[31:28],
	// ack_minor[34:32], ack_code[42:35], zeros above
);

	logic                  s1_valid_q;
	logic [7:0]            data_s1;
	logic                  last_s1;
	logic                  out_free;
	logic                  advance;
	srfc_pkg::frame_snap_t snap;
	srfc_pkg::result_t     result;

	// A byte that ends no body never waits for the output side.
	assign advance  = s1_valid_q && (!last_s1 || out_free);
	assign s_tready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	srfc_frame_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.consume   (advance),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.snap      (snap)
	);

	srfc_verdict u_verdict (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && last_s1),
		.snap      (snap),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_free  (out_free),
		.result    (result)
	);

	assign m_tdata = {{(srfc_pkg::TDATA_W - $bits(srfc_pkg::result_t)){1'b0}}, result};

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !advance |=> s1_valid_q && $stable(data_s1) && $stable(last_s1))
		else $error("stalled input stage lost its byte");

	a_plain_byte_flows: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !last_s1 |-> s_tready)
		else $error("non-final byte stalled the input");

	a_stall_only_on_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a waiting verdict");

endmodule

[design/srfc_frame_state.sv]
// ----------------------------------------------------------------------------
// srfc_frame_state
// Byte count, running sum and captured header bytes of the current body.
// ----------------------------------------------------------------------------
module srfc_frame_state (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 consume,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	output srfc_pkg::frame_snap_t snap
);

	srfc_pkg::frame_snap_t state_q;

	// The snapshot already includes the byte being consumed.
	always_comb begin
		snap = state_q;
		case (state_q.count)
			srfc_pkg::POS_CMD:    snap.cmd = data_byte;
			srfc_pkg::POS_LEN_LO: snap.len[7:0] = data_byte;
			srfc_pkg::POS_LEN_HI: snap.len[15:8] = data_byte;
			srfc_pkg::POS_FIRST:  snap.first = data_byte;
			srfc_pkg::POS_SECOND: snap.second = data_byte;
			default: ;
		endcase
		snap.sum = state_q.sum + data_byte;
		if (state_q.count != srfc_pkg::COUNT_MAX) begin
			snap.count = state_q.count + 17'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (consume) begin
			if (last_byte) begin
				state_q <= '0;
			end else begin
				state_q <= snap;
			end
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		consume && last_byte |=> state_q.count == '0 && state_q.sum == '0)
		else $error("frame state not cleared after the last byte");

	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		consume && !last_byte && state_q.count != srfc_pkg::COUNT_MAX
		|=> state_q.count == $past(state_q.count) + 17'd1)
		else $error("byte count did not advance by one");

	a_count_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!consume |=> $stable(state_q))
		else $error("frame state changed without a consumed byte");

endmodule

[design/srfc_verdict.sv]
// ----------------------------------------------------------------------------
// srfc_verdict
// Frame checks and classification, held in the result register.
// ----------------------------------------------------------------------------
module srfc_verdict (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  srfc_pkg::frame_snap_t snap,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic                  out_free,
	output srfc_pkg::result_t     result
);

	srfc_pkg::result_t  res;
	srfc_pkg::status_t  status;
	logic [3:0]         major;
	logic [2:0]         minor;
	logic [15:0]        plen;
	logic [16:0]        expect_count;
	logic               valid_q;
	srfc_pkg::result_t  result_q;

	assign major        = snap.cmd[7:4];
	assign minor        = snap.cmd[3:1];
	assign plen         = snap.len - 16'd1;
	assign expect_count = {1'b0, snap.len} + srfc_pkg::LEN_OVERHEAD;

	always_comb begin
		res    = '0;
		status = srfc_pkg::ST_OK;
		if (snap.count < srfc_pkg::MIN_BODY) begin
			status = srfc_pkg::ST_SHORT;
		end else if (snap.cmd[0]) begin
			status = srfc_pkg::ST_CMDBIT;
		end else if (snap.len == '0 || expect_count != snap.count) begin
			status = srfc_pkg::ST_LENGTH;
		end else if (snap.sum != srfc_pkg::CHECK_SUM) begin
			status = srfc_pkg::ST_SUM;
		end else begin
			res.kind           = srfc_pkg::KIND_OTHER;
			res.cmd_major      = major;
			res.cmd_minor      = minor;
			res.payload_length = plen;
			if (major == srfc_pkg::MAJOR_MSG && minor == srfc_pkg::MINOR_MSG_ACK
					&& plen >= srfc_pkg::ACK_MIN_PLEN) begin
				if (snap.first[0]) begin
					status = srfc_pkg::ST_ACKBIT;
				end else begin
					res.kind      = srfc_pkg::KIND_ACK;
					res.ack_major = snap.first[7:4];
					res.ack_minor = snap.first[3:1];
					res.ack_code  = snap.second;
				end
			end else if (major == srfc_pkg::MAJOR_OTHER && minor == srfc_pkg::MINOR_EVK) begin
				if (plen > srfc_pkg::RESP_MAX) begin
					status = srfc_pkg::ST_TOOLONG;
				end else begin
					res.kind = srfc_pkg::KIND_RESP;
				end
			end
		end
		// A failed frame reports nothing but its status.
		if (status != srfc_pkg::ST_OK) begin
			res = '0;
		end
		res.status = status;
	end

	assign out_free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign result    = result_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !valid_q || out_ready)
		else $error("pending verdict overwritten");

	a_fail_is_bare: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && result_q.status != srfc_pkg::ST_OK
		|-> result_q.kind == srfc_pkg::KIND_OTHER && result_q.payload_length == '0
			&& result_q.ack_code == '0)
		else $error("failed verdict carries field values");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_q)
		else $error("loaded verdict not presented");

endmodule
